/* sv/rba_pkg.sv */
// ----------------------------------------------------------------------------
// rba_pkg - ring buffer allocator shared definitions
// Field widths, item structs, command/status codes and datapath controls.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int CAP_BITS = 20;
  localparam int OFF_W    = CAP_BITS;
  localparam int SZ_W     = CAP_BITS + 1;
  localparam int ALIGN_W  = 5;
  // wide enough for the largest alignment pad plus size and tail
  localparam int WIDE_W   = ((2 ** ALIGN_W) > SZ_W ? (2 ** ALIGN_W) : SZ_W) + 2;
  localparam int STAT_W   = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER   = 2'd2;

  localparam logic [SZ_W-1:0] CAP_MAX = SZ_W'(1) << CAP_BITS;

  typedef struct packed {
    logic               command;
    logic [SZ_W-1:0]    request_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [SZ_W-1:0]    release_bytes;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  block_offset;
    logic [SZ_W-1:0]   charged_size;
    logic [SZ_W-1:0]   free_bytes;
    logic [SZ_W-1:0]   largest_free;
  } out_item_t;

  typedef struct packed {
    logic ld_req;
    logic ld_tail;
    logic ld_pad;
    logic exec;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/rba_ctrl.sv */
// ----------------------------------------------------------------------------
// rba_ctrl - ring buffer allocator sequencer
// Steps one item through tail, padding, update, tail again and report.
// ----------------------------------------------------------------------------
module rba_ctrl import rba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL,
    S_PAD,
    S_EXEC,
    S_RTAIL,
    S_REPORT
  } state_t;

  state_t state_r;
  logic   in_stall_r;
  logic   accept;

  assign accept   = in_valid && !in_stall_r;
  assign in_stall = in_stall_r;

  always_comb begin
    dp_cmd         = '0;
    dp_cmd.ld_req  = (state_r == S_IDLE) && accept;
    dp_cmd.ld_tail = (state_r == S_TAIL) || (state_r == S_RTAIL);
    dp_cmd.ld_pad  = (state_r == S_PAD);
    dp_cmd.exec    = (state_r == S_EXEC);
    dp_cmd.ld_out  = (state_r == S_REPORT) && dp_stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r    <= S_TAIL;
            in_stall_r <= 1'b1;
          end
        end
        S_TAIL:  state_r <= S_PAD;
        S_PAD:   state_r <= S_EXEC;
        S_EXEC:  state_r <= S_RTAIL;
        S_RTAIL: state_r <= S_REPORT;
        S_REPORT: begin
          // hold until the result register has room
          if (dp_stat.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* sv/rba_dp.sv */
// ----------------------------------------------------------------------------
// rba_dp - ring buffer allocator datapath
// Ring state, capacity register, per-item arithmetic and result register.
// ----------------------------------------------------------------------------
module rba_dp import rba_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  in_item_t        in_item,
  input  logic            cfg_we,
  input  logic [SZ_W-1:0] cfg_wdata,
  input  dp_cmd_t         dp_cmd,
  output dp_stat_t        dp_stat,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item
);

  logic [SZ_W-1:0]   cap_r;
  logic [OFF_W-1:0]  head_r;
  logic [SZ_W-1:0]   used_r;
  in_item_t          req_r;
  logic [OFF_W-1:0]  tail_r;
  logic [WIDE_W-1:0] apad_r;
  logic [SZ_W-1:0]   room_r;
  logic [STAT_W-1:0] status_r;
  logic [OFF_W-1:0]  offset_r;
  logic [SZ_W-1:0]   charged_r;
  out_item_t         out_r;
  logic              out_valid_r;

  // tail = (head + used) mod capacity, sum stays below twice the capacity
  logic [SZ_W:0]     tsum;
  logic [SZ_W:0]     twrap;

  always_comb begin
    tsum  = (SZ_W+1)'(head_r) + (SZ_W+1)'(used_r);
    twrap = tsum;
    if ((cap_r != '0) && (tsum >= (SZ_W+1)'(cap_r))) twrap = tsum - (SZ_W+1)'(cap_r);
  end

  // alignment pad
  logic [WIDE_W-1:0] align_w, amask_w, tail_w, up_w, apad_w;

  always_comb begin
    align_w = WIDE_W'(1) << req_r.align_log2;
    amask_w = align_w - WIDE_W'(1);
    tail_w  = WIDE_W'(tail_r);
    up_w    = (tail_w + amask_w) & ~amask_w;
    apad_w  = up_w - tail_w;
  end

  // update step
  logic [WIDE_W-1:0] size_w, cap_w, pad_w, need_w;
  logic [SZ_W-1:0]   wpad;
  logic              over_end, rej;
  logic [SZ_W-1:0]   bytes;
  logic [SZ_W:0]     hsum, hwrap;
  logic [SZ_W-1:0]   used_dec;

  always_comb begin
    size_w   = WIDE_W'(req_r.request_size);
    cap_w    = WIDE_W'(cap_r);
    wpad     = cap_r - SZ_W'(tail_r);
    over_end = (used_r != cap_r) && ((tail_w + size_w + apad_r) > cap_w);
    pad_w    = over_end ? WIDE_W'(wpad) : apad_r;
    need_w   = pad_w + size_w;
    rej      = (req_r.request_size == '0) || (cap_r == '0) ||
               (WIDE_W'(room_r) < need_w);
    bytes    = req_r.release_bytes;
    hsum     = (SZ_W+1)'(head_r) + (SZ_W+1)'(bytes);
    hwrap    = hsum;
    if ((cap_r != '0) && (hsum >= (SZ_W+1)'(cap_r))) hwrap = hsum - (SZ_W+1)'(cap_r);
    used_dec = used_r - bytes;
  end

  // report step
  logic [SZ_W-1:0] free_now, end_gap, largest;

  always_comb begin
    free_now = cap_r - used_r;
    end_gap  = cap_r - SZ_W'(tail_r);
    if (used_r == '0) begin
      largest = cap_r;
    end else if (used_r >= cap_r) begin
      largest = '0;
    end else if (tail_r >= head_r) begin
      largest = (end_gap > SZ_W'(head_r)) ? end_gap : SZ_W'(head_r);
    end else begin
      largest = SZ_W'(head_r) - SZ_W'(tail_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= '0;
      head_r <= '0;
      used_r <= '0;
    end else if (cfg_we) begin
      cap_r  <= (cfg_wdata > CAP_MAX) ? CAP_MAX : cfg_wdata;
      head_r <= '0;
      used_r <= '0;
    end else if (dp_cmd.exec) begin
      if (req_r.command == CMD_ALLOC) begin
        if (!rej) used_r <= used_r + need_w[SZ_W-1:0];
      end else if ((bytes <= used_r) && (bytes != '0)) begin
        used_r <= used_dec;
        head_r <= (used_dec == '0) ? '0 : hwrap[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.ld_req) req_r <= in_item;
    if (dp_cmd.ld_tail) tail_r <= twrap[OFF_W-1:0];
    if (dp_cmd.ld_pad) begin
      apad_r <= apad_w;
      room_r <= cap_r - used_r;
    end
    if (dp_cmd.exec) begin
      status_r  <= ST_OK;
      offset_r  <= '0;
      charged_r <= '0;
      if (req_r.command == CMD_ALLOC) begin
        if (rej) begin
          status_r <= ST_REJECT;
        end else begin
          // a wrapped block lands at offset zero
          offset_r  <= over_end ? '0 : tail_r + apad_r[OFF_W-1:0];
          charged_r <= need_w[SZ_W-1:0];
        end
      end else if (bytes > used_r) begin
        status_r <= ST_OVER;
      end
    end
    if (dp_cmd.ld_out) begin
      out_r.status       <= status_r;
      out_r.block_offset <= offset_r;
      out_r.charged_size <= charged_r;
      out_r.free_bytes   <= free_now;
      out_r.largest_free <= largest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign dp_stat.out_free = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_item         = out_r;

endmodule

/* sv/ring_buffer_allocator.sv */
// ----------------------------------------------------------------------------
// ring_buffer_allocator - byte ring allocator with alignment
// Allocates aligned blocks at the tail of a ring and frees bytes at the head.
// ----------------------------------------------------------------------------
// One item is handled at a time. An accepted item passes through the
// sequencer's steps (tail, alignment pad, state update, tail again, report)
// before it reaches the result register, and a new item is accepted only
// once the sequencer is back in idle after its report step.
// The result register lets the next item in while a result waits; a result
// left stalled holds the following item in its report step. A capacity write
// resets the ring to empty and must only be made while the block is idle.
module ring_buffer_allocator import rba_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item,
  input  logic            cfg_we,
  input  logic [SZ_W-1:0] cfg_wdata
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  rba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* sv/rba_checker.sv */
// ----------------------------------------------------------------------------
// rba_checker - port-level checks for the ring buffer allocator
// Watches the top level's channels and bound to every instance of it.
// ----------------------------------------------------------------------------
module rba_checker import rba_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input out_item_t       out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // one item in flight: an accepted item blocks the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.largest_free <= out_item.free_bytes)
    else $error("largest free block exceeds free bytes");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |->
      (out_item.block_offset == '0) && (out_item.charged_size == '0))
    else $error("failed item reports an offset or charge");

endmodule

bind ring_buffer_allocator rba_checker u_rba_checker (.*);

/* bench/tb_ring_buffer_allocator.sv */
// ----------------------------------------------------------------------------
// tb_ring_buffer_allocator - self-checking bench for the ring allocator
// Directed rows for reset, capacity extremes, rejections and over-release, then
// random allocate/release traffic under several capacities and idling patterns.
// Results are checked against a row's expected item or a predicted ring state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ring_buffer_allocator;
  import rba_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SEGMENTS       = 9;
  localparam int SEG_ITEMS      = 106;
  localparam int MAX_PRINTS     = 50;

  typedef enum {ROW_CFG, ROW_ALLOC, ROW_FREE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bit [SZ_W-1:0]      val;
    bit [ALIGN_W-1:0]   align;
    bit                 typed;
    out_item_t          want;
  } plan_row_t;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_item_t        in_item   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_item;
  logic            cfg_we    = 1'b0;
  logic [SZ_W-1:0] cfg_wdata = '0;

  ring_buffer_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted ring state
  bit [SZ_W-1:0]   ring_cap  = '0;
  bit [OFF_W-1:0]  ring_head = '0;
  bit [SZ_W-1:0]   ring_used = '0;
  longint unsigned held_blocks[$];  // charged sizes still live, oldest first

  out_item_t   replies_due[$];
  plan_row_t   plan_q[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 31;
  int          recv_stall_pct = 82;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned ring_wrap(longint unsigned v, longint unsigned cap);
    if (cap != 0 && v >= cap) return v - cap;
    return v;
  endfunction

  function automatic out_item_t alloc_or_release(in_item_t it);
    out_item_t       res;
    longint unsigned cap, hd, us, tail, align, apad, wpad, pad, sz, rel, left, big;
    res = '0;
    cap = ring_cap;
    hd  = ring_head;
    us  = ring_used;
    if (it.command == CMD_ALLOC) begin
      sz = it.request_size;
      if (sz == 0 || cap == 0) begin
        res.status = ST_REJECT;
      end else begin
        align = 64'd1 << it.align_log2;
        tail  = ring_wrap(hd + us, cap);
        apad  = ((tail + align - 1) & ~(align - 1)) - tail;
        // block would run past the end: pad to the end and restart at zero
        wpad  = (us != cap && tail + sz + apad > cap) ? cap - tail : 0;
        pad   = (wpad != 0) ? wpad : apad;
        if (cap - us < pad + sz) begin
          res.status = ST_REJECT;
        end else begin
          us += pad;
          res.block_offset = OFF_W'(ring_wrap(hd + us, cap));
          res.charged_size = SZ_W'(sz + pad);
          us += sz;
          held_blocks.push_back(sz + pad);
        end
      end
    end else begin
      rel = it.release_bytes;
      if (rel > us) begin
        res.status = ST_OVER;
      end else if (rel != 0) begin
        hd = ring_wrap(hd + rel, cap);
        us -= rel;
        if (us == 0) hd = 0;
        left = rel;
        while (left != 0 && held_blocks.size() != 0) begin
          if (held_blocks[0] <= left) begin
            left -= held_blocks[0];
            void'(held_blocks.pop_front());
          end else begin
            held_blocks[0] -= left;
            left = 0;
          end
        end
      end
    end
    if (us == 0) begin
      big = cap;
    end else if (us >= cap) begin
      big = 0;
    end else begin
      tail = ring_wrap(hd + us, cap);
      if (tail >= hd) big = (cap - tail > hd) ? cap - tail : hd;
      else big = hd - tail;
    end
    ring_head = OFF_W'(hd);
    ring_used = SZ_W'(us);
    res.free_bytes   = SZ_W'(cap - us);
    res.largest_free = SZ_W'(big);
    return res;
  endfunction

  function automatic in_item_t make_item();
    in_item_t    it;
    int unsigned pick, top;
    it.command       = 1'($urandom_range(1));
    it.request_size  = SZ_W'($urandom_range(0, (1 << SZ_W) - 1));
    it.align_log2    = ALIGN_W'($urandom_range(0, (1 << ALIGN_W) - 1));
    it.release_bytes = SZ_W'($urandom_range(0, (1 << SZ_W) - 1));
    pick = $urandom_range(99);
    if (pick < 10) return it;
    if (pick < 55) begin
      it.command = CMD_ALLOC;
      top = (ring_cap > 3) ? ring_cap / 3 : 1;
      if (ring_cap != 0 && $urandom_range(15) == 0) top = ring_cap;
      it.request_size = SZ_W'($urandom_range(1, top));
      it.align_log2   = ($urandom_range(3) == 0) ? ALIGN_W'($urandom_range(0, CAP_BITS))
                                                 : ALIGN_W'($urandom_range(0, 3));
    end else begin
      it.command = CMD_FREE;
      if (held_blocks.size() != 0 && pick < 92)
        it.release_bytes = SZ_W'(held_blocks[0]);
      else
        it.release_bytes = SZ_W'($urandom_range(0, ring_used + 1));
    end
    return it;
  endfunction

  task automatic add_row(row_kind_t k, bit [SZ_W-1:0] v, int unsigned al, bit typed,
                         out_item_t want);
    plan_row_t r;
    r.kind  = k;
    r.val   = v;
    r.align = ALIGN_W'(al);
    r.typed = typed;
    r.want  = want;
    plan_q.push_back(r);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t calc;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    calc = alloc_or_release(it);
    replies_due.push_back(typed ? want : calc);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(bit [SZ_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_cap  = (v > CAP_MAX) ? CAP_MAX : v;
    ring_head = '0;
    ring_used = '0;
    held_blocks.delete();
  endtask

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // receiver: random stall, check each accepted result against the oldest due
  always @(posedge clk) begin
    out_item_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("result with none due, status", out_item.status, 0);
      end else begin
        want = replies_due.pop_front();
        if (out_item.status !== want.status)
          flag_mismatch("status", out_item.status, want.status);
        if (out_item.block_offset !== want.block_offset)
          flag_mismatch("block_offset", out_item.block_offset, want.block_offset);
        if (out_item.charged_size !== want.charged_size)
          flag_mismatch("charged_size", out_item.charged_size, want.charged_size);
        if (out_item.free_bytes !== want.free_bytes)
          flag_mismatch("free_bytes", out_item.free_bytes, want.free_bytes);
        if (out_item.largest_free !== want.largest_free)
          flag_mismatch("largest_free", out_item.largest_free, want.largest_free);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("[ring_buffer_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t      it;
    bit [SZ_W-1:0] cap_val;
    int            seg, n;

    // no capacity yet: allocations rejected, nonzero free flagged, zero free ok
    add_row(ROW_ALLOC, 16, 0, 1, '{ST_REJECT, 20'd0, 21'd0, 21'd0, 21'd0});
    add_row(ROW_FREE,  5,  0, 1, '{ST_OVER,   20'd0, 21'd0, 21'd0, 21'd0});
    add_row(ROW_FREE,  0,  0, 1, '{ST_OK,     20'd0, 21'd0, 21'd0, 21'd0});
    // oversized write saturates to the largest ring
    add_row(ROW_CFG,   21'h1FFFFF, 0, 0, '0);
    add_row(ROW_ALLOC, 0, 3, 1, '{ST_REJECT, 20'd0, 21'd0, CAP_MAX, CAP_MAX});
    add_row(ROW_ALLOC, CAP_MAX, 0, 1, '{ST_OK, 20'd0, CAP_MAX, 21'd0, 21'd0});
    add_row(ROW_ALLOC, 1, 0, 1, '{ST_REJECT, 20'd0, 21'd0, 21'd0, 21'd0});
    add_row(ROW_FREE,  21'h1FFFFF, 0, 1, '{ST_OVER, 20'd0, 21'd0, 21'd0, 21'd0});
    add_row(ROW_FREE,  CAP_MAX, 0, 1, '{ST_OK, 20'd0, 21'd0, CAP_MAX, CAP_MAX});
    add_row(ROW_CFG,   100, 0, 0, '0);
    add_row(ROW_ALLOC, 10, 0, 1, '{ST_OK, 20'd0, 21'd10, 21'd90, 21'd90});
    add_row(ROW_ALLOC, 5, 4, 0, '0);
    add_row(ROW_ALLOC, 50, 31, 0, '0);   // alignment far beyond the ring
    add_row(ROW_FREE,  10, 0, 0, '0);
    add_row(ROW_ALLOC, 75, 0, 0, '0);
    add_row(ROW_ALLOC, 5, 0, 0, '0);     // wraps to offset zero
    add_row(ROW_FREE,  200, 0, 0, '0);
    add_row(ROW_FREE,  0, 0, 0, '0);
    add_row(ROW_ALLOC, 1, 7, 0, '0);
    add_row(ROW_CFG,   1, 0, 0, '0);
    add_row(ROW_ALLOC, 1, 0, 1, '{ST_OK, 20'd0, 21'd1, 21'd0, 21'd0});
    add_row(ROW_ALLOC, 1, 0, 1, '{ST_REJECT, 20'd0, 21'd0, 21'd0, 21'd0});
    add_row(ROW_FREE,  1, 0, 1, '{ST_OK, 20'd0, 21'd0, 21'd1, 21'd1});
    add_row(ROW_ALLOC, 2, 0, 1, '{ST_REJECT, 20'd0, 21'd0, 21'd1, 21'd1});
    add_row(ROW_CFG,   CAP_MAX, 0, 0, '0);
    add_row(ROW_ALLOC, 21'h1FFFFF, 0, 0, '0);
    add_row(ROW_CFG,   0, 0, 0, '0);
    add_row(ROW_ALLOC, 1, 0, 1, '{ST_REJECT, 20'd0, 21'd0, 21'd0, 21'd0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        write_capacity(plan_q[i].val);
      end else begin
        it = '0;
        if (plan_q[i].kind == ROW_FREE) begin
          it.command       = CMD_FREE;
          it.release_bytes = plan_q[i].val;
        end else begin
          it.command      = CMD_ALLOC;
          it.request_size = plan_q[i].val;
          it.align_log2   = plan_q[i].align;
        end
        send_item(it, plan_q[i].typed, plan_q[i].want);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      unique case (seg / 3)
        0:       begin send_idle_pct = 31; recv_stall_pct = 82; end
        1:       begin send_idle_pct = 82; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      unique case (seg)
        0:       cap_val = 64;
        1:       cap_val = 21'h1FFFFF;
        2:       cap_val = 1;
        3:       cap_val = 100;
        4:       cap_val = 4096;
        5:       cap_val = SZ_W'($urandom_range(2, 2000));
        6:       cap_val = CAP_MAX;
        7:       cap_val = 37;
        default: cap_val = SZ_W'($urandom_range(2, 21'h1FFFFF));
      endcase
      write_capacity(cap_val);
      for (n = 0; n < SEG_ITEMS; n++) begin
        // hold the sender until the pipeline has emptied
        if (n == SEG_ITEMS / 2 && seg % 3 == 0) wait_drained();
        send_item(make_item(), 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatch_count == 0 && replies_due.size() == 0)
      $display("[ring_buffer_allocator] OK");
    else
      $display("[ring_buffer_allocator] ERROR");
    $finish;
  end

endmodule
